// ===== design/box_centre_ray_collision_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the box collider block
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef BOX_CENTRE_RAY_COLLISION_TOP_DEFINES_SVH
`define BOX_CENTRE_RAY_COLLISION_TOP_DEFINES_SVH

// same-cycle implication
`define BCRC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bcrc_pkg.sv =====
// ---------------------------------------------------------------------------
// bcrc_pkg
// Widths, payload structs and register codes of the box collider block.
// ---------------------------------------------------------------------------
package bcrc_pkg;

  localparam int unsigned PosW       = 32;
  localparam int unsigned ValW       = 32;
  localparam int unsigned AbsW       = 32;
  localparam int unsigned LenW       = 33;
  localparam int unsigned SqW        = 2 * LenW;
  localparam int unsigned FracW      = 16;
  localparam int unsigned ExtW       = 48;
  localparam int unsigned ReachW     = 48;
  localparam int unsigned SumW       = ReachW + 1;
  localparam int unsigned NumW       = 81;
  localparam int unsigned OffW       = 34;
  localparam int unsigned AddrW      = 4;
  localparam int unsigned QueueDepth = 2;

  localparam logic [ValW-1:0] CfgReset = 32'h0001_0000;

  typedef enum logic [1:0] {
    REG_EXTENT_X = 2'd0,
    REG_EXTENT_Y = 2'd1,
    REG_SCALE_X  = 2'd2,
    REG_SCALE_Y  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic            op;
    logic [PosW-1:0] self_pos_x;
    logic [PosW-1:0] self_pos_y;
    logic [PosW-1:0] other_pos_x;
    logic [PosW-1:0] other_pos_y;
    logic [ValW-1:0] other_extent_x;
    logic [ValW-1:0] other_extent_y;
    logic [ValW-1:0] other_scale_x;
    logic [ValW-1:0] other_scale_y;
    logic [ValW-1:0] other_radius;
  } in_t;

  typedef struct packed {
    logic            colliding;
    logic [PosW-1:0] pushed_pos_x;
    logic [PosW-1:0] pushed_pos_y;
    logic            coincident;
  } out_t;

  typedef struct packed {
    logic [ValW-1:0] extent_x;
    logic [ValW-1:0] extent_y;
    logic [ValW-1:0] scale_x;
    logic [ValW-1:0] scale_y;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic            op;
    logic            coincident;
    logic            neg_x;
    logic            neg_y;
    logic [AbsW-1:0] abs_x;
    logic [AbsW-1:0] abs_y;
    logic [PosW-1:0] self_pos_x;
    logic [PosW-1:0] self_pos_y;
    logic [PosW-1:0] other_pos_x;
    logic [PosW-1:0] other_pos_y;
    logic [ValW-1:0] other_extent_x;
    logic [ValW-1:0] other_extent_y;
    logic [ValW-1:0] other_scale_x;
    logic [ValW-1:0] other_scale_y;
    logic [ValW-1:0] other_radius;
  } job_t;

endpackage

// ===== design/box_centre_ray_collision_top.sv =====
// ---------------------------------------------------------------------------
// box_centre_ray_collision_top
// Box collider test against a circle or box along the centre line.
// ---------------------------------------------------------------------------
// Usage:
//   Drive item_i and raise start; the transaction is taken on a rising edge
//   where start is high and busy is low. One result per transaction appears
//   on result_o with done_o high for exactly one cycle, in issue order.
//   A transaction passes the front register and the queue, then the back
//   with its 33-stage square root, its 48-stage reach dividers and its
//   34-stage push-out dividers, all one bit per stage.
//   Throughput is one transaction per cycle; busy only rises if the queue
//   fills, which the never-stalling back keeps from happening in practice.
//   The receiver cannot stall; results must be captured when done_o is high.
//   The APB port holds this box's extents and scales at byte offsets 0, 4,
//   8 and 12; write it only while no transaction is in flight.
//   Reset clears the pipeline valid bits and queue and sets all four
//   registers to 1.0 (0x0001_0000). No clearing pass is needed.
// ---------------------------------------------------------------------------
module box_centre_ray_collision_top #(
  parameter int unsigned QUEUE_DEPTH = bcrc_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  bcrc_pkg::in_t              item_i,
  output logic                       done_o,
  output bcrc_pkg::out_t             result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bcrc_pkg::AddrW-1:0] paddr,
  input  logic [bcrc_pkg::ValW-1:0]  pwdata,
  output logic [bcrc_pkg::ValW-1:0]  prdata,
  output logic                       pready
);
  import bcrc_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  logic push, full, q_valid;
  job_t f_job, q_job;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.extent_x <= CfgReset;
      cfg_q.extent_y <= CfgReset;
      cfg_q.scale_x  <= CfgReset;
      cfg_q.scale_y  <= CfgReset;
    end else if (wr_en) begin
      case (reg_idx)
        REG_EXTENT_X: cfg_q.extent_x <= pwdata;
        REG_EXTENT_Y: cfg_q.extent_y <= pwdata;
        REG_SCALE_X:  cfg_q.scale_x  <= pwdata;
        REG_SCALE_Y:  cfg_q.scale_y  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_EXTENT_X: prdata = cfg_q.extent_x;
      REG_EXTENT_Y: prdata = cfg_q.extent_y;
      REG_SCALE_X:  prdata = cfg_q.scale_x;
      REG_SCALE_Y:  prdata = cfg_q.scale_y;
      default:      prdata = '0;
    endcase
  end

  bcrc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .item_i  (item_i),
    .push_o  (push),
    .job_o   (f_job),
    .full_i  (full)
  );

  bcrc_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (f_job),
    .full_o  (full),
    .pop_i   (q_valid),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  bcrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .job_i       (q_job),
    .cfg_i       (cfg_q),
    .out_valid_o (done_o),
    .out_o       (result_o)
  );

endmodule

// ===== design/bcrc_front.sv =====
// ---------------------------------------------------------------------------
// bcrc_front
// Takes commands, forms the centre difference and flags coincident centres.
// ---------------------------------------------------------------------------
module bcrc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  bcrc_pkg::in_t  item_i,
  output logic           push_o,
  output bcrc_pkg::job_t job_o,
  input  logic           full_i
);
  import bcrc_pkg::*;

  logic       valid_q, valid_d;
  job_t       job_q, job_d;
  logic       take;
  logic [PosW:0] dx, dy;

  assign busy_o = valid_q & full_i;
  assign take   = start_i & ~busy_o;
  assign push_o = valid_q & ~full_i;
  assign job_o  = job_q;

  always_comb begin
    dx = {item_i.other_pos_x[PosW-1], item_i.other_pos_x}
       - {item_i.self_pos_x[PosW-1], item_i.self_pos_x};
    dy = {item_i.other_pos_y[PosW-1], item_i.other_pos_y}
       - {item_i.self_pos_y[PosW-1], item_i.self_pos_y};
    job_d.op             = item_i.op;
    job_d.coincident     = (dx == '0) && (dy == '0);
    job_d.neg_x          = dx[PosW];
    job_d.neg_y          = dy[PosW];
    job_d.abs_x          = dx[PosW] ? AbsW'(~dx + 1'b1) : AbsW'(dx);
    job_d.abs_y          = dy[PosW] ? AbsW'(~dy + 1'b1) : AbsW'(dy);
    job_d.self_pos_x     = item_i.self_pos_x;
    job_d.self_pos_y     = item_i.self_pos_y;
    job_d.other_pos_x    = item_i.other_pos_x;
    job_d.other_pos_y    = item_i.other_pos_y;
    job_d.other_extent_x = item_i.other_extent_x;
    job_d.other_extent_y = item_i.other_extent_y;
    job_d.other_scale_x  = item_i.other_scale_x;
    job_d.other_scale_y  = item_i.other_scale_y;
    job_d.other_radius   = item_i.other_radius;
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q <= job_d;
    end
  end

endmodule

// ===== design/bcrc_queue.sv =====
// ---------------------------------------------------------------------------
// bcrc_queue
// Short FIFO of classified items between front and back.
// ---------------------------------------------------------------------------
`include "box_centre_ray_collision_top_defines.svh"

module bcrc_queue #(
  parameter int unsigned Depth = bcrc_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bcrc_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bcrc_pkg::job_t job_o
);
  import bcrc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  `BCRC_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CntW'(Depth), "queue count above depth")
  `BCRC_ASSERT_IMPL(a_no_overflow, push_i, !full_o || pop_i, "push into full queue")
  `BCRC_ASSERT_IMPL(a_no_underflow, pop_i, valid_o, "pop from empty queue")

endmodule

// ===== design/bcrc_isqrt.sv =====
// ---------------------------------------------------------------------------
// bcrc_isqrt
// Pipelined integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
module bcrc_isqrt #(
  parameter int unsigned RootW = bcrc_pkg::LenW
) (
  input  logic               clk_i,
  input  logic [2*RootW-1:0] rad_i,
  output logic [RootW-1:0]   root_o
);
  localparam int unsigned RemW = RootW + 2;

  logic [2*RootW-1:0] rad_q  [RootW];
  logic [RemW-1:0]    rem_q  [RootW];
  logic [RootW-1:0]   root_q [RootW+1];
  logic [RemW+1:0]    cur    [RootW];
  logic [RemW+1:0]    trial  [RootW];
  logic [RemW+1:0]    diff   [RootW];
  logic               ge     [RootW];

  always_comb begin
    for (int k = 1; k <= RootW; k++) begin
      cur[k-1]   = {rem_q[k-1], rad_q[k-1][2*(RootW-k) +: 2]};
      trial[k-1] = {2'b00, root_q[k-1], 2'b01};
      ge[k-1]    = cur[k-1] >= trial[k-1];
      diff[k-1]  = cur[k-1] - trial[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= rad_i;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    for (int k = 1; k <= RootW; k++) begin
      root_q[k] <= {root_q[k-1][RootW-2:0], ge[k-1]};
      if (k < RootW) begin
        rad_q[k] <= rad_q[k-1];
        rem_q[k] <= ge[k-1] ? diff[k-1][RemW-1:0] : cur[k-1][RemW-1:0];
      end
    end
  end

  assign root_o = root_q[RootW];

endmodule

// ===== design/bcrc_div.sv =====
// ---------------------------------------------------------------------------
// bcrc_div
// Pipelined restoring divider with quotient saturation, one bit per stage.
// ---------------------------------------------------------------------------
module bcrc_div #(
  parameter int unsigned NumW = bcrc_pkg::NumW,
  parameter int unsigned DenW = bcrc_pkg::AbsW,
  parameter int unsigned QuoW = bcrc_pkg::ReachW
) (
  input  logic            clk_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QuoW-1:0] quo_o
);
  localparam int unsigned HiW = NumW - QuoW;

  logic [DenW-1:0] rem_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [QuoW-1:0] lo_q  [QuoW];
  logic [QuoW-1:0] quo_q [QuoW+1];
  logic            sat_q [QuoW+1];
  logic [DenW:0]   cur   [QuoW];
  logic [DenW:0]   diff  [QuoW];
  logic            ge    [QuoW];
  logic            sat;

  // quotient overflows QuoW bits exactly when the top part reaches the divisor
  assign sat = num_i[NumW-1:QuoW] >= HiW'(den_i);

  always_comb begin
    for (int k = 1; k <= QuoW; k++) begin
      cur[k-1]  = {rem_q[k-1], lo_q[k-1][QuoW-k]};
      ge[k-1]   = cur[k-1] >= {1'b0, den_q[k-1]};
      diff[k-1] = cur[k-1] - {1'b0, den_q[k-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i[QuoW +: DenW];
    den_q[0] <= den_i;
    lo_q[0]  <= num_i[QuoW-1:0];
    quo_q[0] <= '0;
    sat_q[0] <= sat;
    for (int k = 1; k <= QuoW; k++) begin
      quo_q[k] <= {quo_q[k-1][QuoW-2:0], ge[k-1]};
      sat_q[k] <= sat_q[k-1];
      if (k < QuoW) begin
        rem_q[k] <= ge[k-1] ? diff[k-1][DenW-1:0] : cur[k-1][DenW-1:0];
        den_q[k] <= den_q[k-1];
        lo_q[k]  <= lo_q[k-1];
      end
    end
  end

  assign quo_o = sat_q[QuoW] ? '1 : quo_q[QuoW];

endmodule

// ===== design/bcrc_back.sv =====
// ---------------------------------------------------------------------------
// bcrc_back
// Distance, reaches, collision test and push-out, fully pipelined.
// ---------------------------------------------------------------------------
`include "box_centre_ray_collision_top_defines.svh"

module bcrc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  bcrc_pkg::job_t job_i,
  input  bcrc_pkg::cfg_t cfg_i,
  output logic           out_valid_o,
  output bcrc_pkg::out_t out_o
);
  import bcrc_pkg::*;

  localparam int unsigned LatSq  = LenW + 1;
  localparam int unsigned LatRch = ReachW + 1;
  localparam int unsigned LatOff = OffW + 1;

  typedef logic [3:0][ExtW-1:0] ext4_t;

  function automatic logic [ExtW-1:0] scale_ext(logic [ValW-1:0] e, logic [ValW-1:0] s);
    logic [2*ValW-1:0] p;
    p = (2*ValW)'(e) * (2*ValW)'(s);
    return p[FracW +: ExtW];
  endfunction

  function automatic logic [PosW-1:0] push_coord(logic [PosW-1:0] oth, logic neg,
                                                  logic [OffW-1:0] off);
    logic [OffW+1:0] o, r;
    o = {{(OffW+2-PosW){oth[PosW-1]}}, oth};
    r = neg ? o + {2'b00, off} : o - {2'b00, off};
    if (!r[OffW+1] && (r[OffW:PosW-1] != '0)) begin
      return {1'b0, {(PosW-1){1'b1}}};
    end else if (r[OffW+1] && (r[OffW:PosW-1] != '1)) begin
      return {1'b1, {(PosW-1){1'b0}}};
    end
    return r[PosW-1:0];
  endfunction

  // stage 1: squares and scaled extents
  logic               v1_q;
  job_t               j1_q;
  logic [2*AbsW-1:0]  sqx_q, sqy_q;
  ext4_t              e1_q;

  always_ff @(posedge clk_i) begin
    j1_q  <= job_i;
    sqx_q <= (2*AbsW)'(job_i.abs_x) * (2*AbsW)'(job_i.abs_x);
    sqy_q <= (2*AbsW)'(job_i.abs_y) * (2*AbsW)'(job_i.abs_y);
    e1_q[0] <= scale_ext(cfg_i.extent_x, cfg_i.scale_x);
    e1_q[1] <= scale_ext(cfg_i.extent_y, cfg_i.scale_y);
    e1_q[2] <= scale_ext(job_i.other_extent_x, job_i.other_scale_x);
    e1_q[3] <= scale_ext(job_i.other_extent_y, job_i.other_scale_y);
  end

  // centre distance
  logic [SqW-1:0]  rad;
  logic [LenW-1:0] len;

  assign rad = SqW'(sqx_q) + SqW'(sqy_q);

  bcrc_isqrt #(.RootW(LenW)) u_isqrt (
    .clk_i  (clk_i),
    .rad_i  (rad),
    .root_o (len)
  );

  logic  va_q [LatSq];
  job_t  ja_q [LatSq];
  ext4_t ea_q [LatSq];

  always_ff @(posedge clk_i) begin
    ja_q[0] <= j1_q;
    ea_q[0] <= e1_q;
    for (int k = 1; k < LatSq; k++) begin
      ja_q[k] <= ja_q[k-1];
      ea_q[k] <= ea_q[k-1];
    end
  end

  // stage 3: extent times distance as two partial products
  logic                     v3_q;
  job_t                     j3_q;
  logic [LenW-1:0]          len3_q;
  logic [3:0][ValW+LenW-1:0] pl3_q;
  logic [3:0][ExtW-ValW+LenW-1:0] ph3_q;

  always_ff @(posedge clk_i) begin
    j3_q   <= ja_q[LatSq-1];
    len3_q <= len;
    for (int i = 0; i < 4; i++) begin
      pl3_q[i] <= (ValW+LenW)'(ea_q[LatSq-1][i][ValW-1:0]) * (ValW+LenW)'(len);
      ph3_q[i] <= (ExtW-ValW+LenW)'(ea_q[LatSq-1][i][ExtW-1:ValW])
                * (ExtW-ValW+LenW)'(len);
    end
  end

  logic [3:0][NumW-1:0]   rnum;
  logic [3:0][ReachW-1:0] reach;

  for (genvar i = 0; i < 4; i++) begin : g_reach
    assign rnum[i] = (NumW'(ph3_q[i]) << ValW) + NumW'(pl3_q[i]);
    bcrc_div #(.NumW(NumW), .DenW(AbsW), .QuoW(ReachW)) u_div (
      .clk_i (clk_i),
      .num_i (rnum[i]),
      .den_i ((i % 2 == 0) ? j3_q.abs_x : j3_q.abs_y),
      .quo_o (reach[i])
    );
  end

  logic            vb_q   [LatRch];
  job_t            jb_q   [LatRch];
  logic [LenW-1:0] lenb_q [LatRch];

  always_ff @(posedge clk_i) begin
    jb_q[0]   <= j3_q;
    lenb_q[0] <= len3_q;
    for (int k = 1; k < LatRch; k++) begin
      jb_q[k]   <= jb_q[k-1];
      lenb_q[k] <= lenb_q[k-1];
    end
  end

  // stage 4: summed reach
  logic              v4_q;
  job_t              j4_q;
  logic [LenW-1:0]   len4_q;
  logic [SumW-1:0]   sum4_q;
  logic [ReachW-1:0] r_self, r_box, r_other;

  always_comb begin
    r_self  = (reach[0] < reach[1]) ? reach[0] : reach[1];
    r_box   = (reach[2] < reach[3]) ? reach[2] : reach[3];
    r_other = jb_q[LatRch-1].op ? r_box : ReachW'(jb_q[LatRch-1].other_radius);
  end

  always_ff @(posedge clk_i) begin
    j4_q   <= jb_q[LatRch-1];
    len4_q <= lenb_q[LatRch-1];
    sum4_q <= SumW'(r_self) + SumW'(r_other);
  end

  // stage 5: collision test, offset partial products
  logic                       v5_q;
  job_t                       j5_q;
  logic [LenW-1:0]            len5_q;
  logic                       coll5_q;
  logic [1:0][2*AbsW-1:0]     pl5_q;
  logic [1:0][SumW-ValW+AbsW-1:0] ph5_q;

  always_ff @(posedge clk_i) begin
    j5_q    <= j4_q;
    len5_q  <= len4_q;
    coll5_q <= SumW'(len4_q) <= sum4_q;
    pl5_q[0] <= (2*AbsW)'(j4_q.abs_x) * (2*AbsW)'(sum4_q[ValW-1:0]);
    pl5_q[1] <= (2*AbsW)'(j4_q.abs_y) * (2*AbsW)'(sum4_q[ValW-1:0]);
    ph5_q[0] <= (SumW-ValW+AbsW)'(j4_q.abs_x) * (SumW-ValW+AbsW)'(sum4_q[SumW-1:ValW]);
    ph5_q[1] <= (SumW-ValW+AbsW)'(j4_q.abs_y) * (SumW-ValW+AbsW)'(sum4_q[SumW-1:ValW]);
  end

  logic [1:0][NumW-1:0] onum;
  logic [1:0][OffW-1:0] off;

  for (genvar i = 0; i < 2; i++) begin : g_off
    assign onum[i] = (NumW'(ph5_q[i]) << ValW) + NumW'(pl5_q[i]);
    bcrc_div #(.NumW(NumW), .DenW(LenW), .QuoW(OffW)) u_div (
      .clk_i (clk_i),
      .num_i (onum[i]),
      .den_i (len5_q),
      .quo_o (off[i])
    );
  end

  logic vc_q    [LatOff];
  job_t jc_q    [LatOff];
  logic collc_q [LatOff];

  always_ff @(posedge clk_i) begin
    jc_q[0]    <= j5_q;
    collc_q[0] <= coll5_q;
    for (int k = 1; k < LatOff; k++) begin
      jc_q[k]    <= jc_q[k-1];
      collc_q[k] <= collc_q[k-1];
    end
  end

  // output stage
  logic out_valid_q;
  out_t out_q;
  job_t jo;

  assign jo = jc_q[LatOff-1];

  always_ff @(posedge clk_i) begin
    if (jo.coincident) begin
      out_q.colliding    <= 1'b0;
      out_q.pushed_pos_x <= jo.self_pos_x;
      out_q.pushed_pos_y <= jo.self_pos_y;
      out_q.coincident   <= 1'b1;
    end else begin
      out_q.colliding    <= collc_q[LatOff-1];
      out_q.pushed_pos_x <= push_coord(jo.other_pos_x, jo.neg_x, off[0]);
      out_q.pushed_pos_y <= push_coord(jo.other_pos_y, jo.neg_y, off[1]);
      out_q.coincident   <= 1'b0;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < LatSq; k++) va_q[k] <= 1'b0;
      for (int k = 0; k < LatRch; k++) vb_q[k] <= 1'b0;
      for (int k = 0; k < LatOff; k++) vc_q[k] <= 1'b0;
    end else begin
      v1_q  <= in_valid_i;
      va_q[0] <= v1_q;
      for (int k = 1; k < LatSq; k++) va_q[k] <= va_q[k-1];
      v3_q  <= va_q[LatSq-1];
      vb_q[0] <= v3_q;
      for (int k = 1; k < LatRch; k++) vb_q[k] <= vb_q[k-1];
      v4_q  <= vb_q[LatRch-1];
      v5_q  <= v4_q;
      vc_q[0] <= v5_q;
      for (int k = 1; k < LatOff; k++) vc_q[k] <= vc_q[k-1];
      out_valid_q <= vc_q[LatOff-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `BCRC_ASSERT_IMPL(a_coin_no_hit, out_valid_q && out_q.coincident, !out_q.colliding,
    "coincident centres reported as colliding")
  `BCRC_ASSERT_NEXT(a_take_advances, in_valid_i, v1_q, "accepted item lost at first stage")
  `BCRC_ASSERT_NEXT(a_out_from_div, vc_q[LatOff-1], out_valid_q,
    "divider result not presented")

endmodule
